/* rtl/spce_pkg.sv */
// Package for the shortest path cost engine: sizes, operation and status codes,
// sequencer states and the hop cost function. Depends on nothing.
`default_nettype none
package spce_pkg;
  localparam int MaxNodes   = 32;
  localparam int NodeBits   = 5;
  localparam int WeightBits = 10;
  localparam int CostBits   = 32;
  localparam int AdjAddrBits = 2 * NodeBits;
  localparam int AdjDepth   = MaxNodes * MaxNodes;

  typedef logic [NodeBits-1:0]   node_t;
  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [CostBits-1:0]   cost_t;
  typedef logic [AdjAddrBits-1:0] adj_addr_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_UNREACH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_EDGE_RD, S_EDGE_WR, S_EDGE_WR2,
    S_SCAN, S_PICK, S_RELAX, S_RELAX_WAIT, S_RELAX_LAST, S_OUT
  } state_t;

  typedef struct packed {
    logic      wr_en;
    adj_addr_t wr_addr;
    logic      wr_valid;
    weight_t   wr_weight;
    adj_addr_t rd_addr;
  } adj_ctl_t;

  function automatic cost_t hop_cost(input weight_t w, input logic tm);
    logic [CostBits-1:0] m;
    m = CostBits'(w) * CostBits'(40) + CostBits'(120);
    return tm ? m : CostBits'(w);
  endfunction

  function automatic cost_t sat_add(input cost_t a, input cost_t b);
    logic [CostBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostBits] ? '1 : s[CostBits-1:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/spce_adj_ram.sv */
// Adjacency table memory: one valid bit and a weight per ordered node pair in one array.
// A clearing pass after reset marks every entry absent before ready rises. Uses spce_pkg.
`default_nettype none
module spce_adj_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spce_pkg::adj_ctl_t ctl,
  output logic                   ready,
  output logic                   rd_valid,
  output spce_pkg::weight_t      rd_weight
);
  import spce_pkg::*;

  logic [WeightBits:0] entry_mem [AdjDepth];
  logic                clr_busy_r;
  adj_addr_t           clr_addr_r;
  logic                wr_en;
  adj_addr_t           wr_addr;
  logic [WeightBits:0] wr_data;

  assign ready   = !clr_busy_r;
  assign wr_en   = clr_busy_r || ctl.wr_en;
  assign wr_addr = clr_busy_r ? clr_addr_r : ctl.wr_addr;
  assign wr_data = clr_busy_r ? '0 : {ctl.wr_valid, ctl.wr_weight};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == adj_addr_t'(AdjDepth - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    {rd_valid, rd_weight} <= entry_mem[ctl.rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/shortest_path_cost_engine.sv */
// Top level of the shortest path cost engine: stream ports, the sequencer with its
// shared add and compare unit, and the per-node cost registers. Uses spce_pkg and spce_adj_ram.
// After reset the adjacency table is cleared in one pass over every entry, during which no
// input beat is taken. An edge add or remove reads the entry for (node_a, node_b), then
// gives its result when the table is left unchanged, or first writes both entries (a, b) and
// (b, a). A query runs, for each settled node, one scan pass over all nodes and one relax pass
// that reads a single adjacency entry per cycle through the one adjacency read port. The
// block takes no input beat while an item is in work.
`default_nettype none
module shortest_path_cost_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // op[1:0], node_a[6:2], node_b[11:7], weight[21:12], time_mode[22]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // status[1:0], path_cost[33:2]
);
  import spce_pkg::*;

  state_t   state_r, state_nxt;
  op_t      op_r;
  node_t    a_r, b_r, u_r, v_r, v_nxt, best_r;
  weight_t  w_r;
  logic     tm_r, found_r;
  cost_t    cu_r, best_cost_r;
  status_t  status_r;
  cost_t    res_cost_r;
  cost_t    cost_r [MaxNodes];
  logic [MaxNodes-1:0] reached_r, settled_r;
  adj_ctl_t ctl;
  logic     ram_ready;
  logic     rd_valid;
  weight_t  rd_weight;
  logic     last_v;
  cost_t    nc;

  spce_adj_ram u_ram (.clk, .rst_n, .ctl, .ready(ram_ready), .rd_valid, .rd_weight);

  assign in_tready  = (state_r == S_IDLE) && ram_ready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, res_cost_r, status_r};
  assign last_v     = (v_r == node_t'(MaxNodes - 1));
  assign nc         = sat_add(cu_r, hop_cost(rd_weight, tm_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    ctl.rd_addr = {a_r, b_r};
    v_nxt       = v_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && ram_ready) begin
        state_nxt = (in_tdata[1:0] == OP_QUERY) ? S_CLEAR :
                    (in_tdata[1:0] == OP_NONE) ? S_OUT : S_EDGE_RD;
      end
      S_EDGE_RD: state_nxt = S_EDGE_WR;
      S_EDGE_WR: begin
        if ((op_r == OP_ADD) != rd_valid) begin
          ctl.wr_en = 1'b1; ctl.wr_addr = {a_r, b_r};
          ctl.wr_valid = (op_r == OP_ADD); ctl.wr_weight = w_r;
          state_nxt = S_EDGE_WR2;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EDGE_WR2: begin
        ctl.wr_en = 1'b1; ctl.wr_addr = {b_r, a_r};
        ctl.wr_valid = (op_r == OP_ADD); ctl.wr_weight = w_r;
        state_nxt = S_OUT;
      end
      S_CLEAR: begin
        v_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        v_nxt = v_r + 1'b1;
        if (last_v) state_nxt = S_PICK;
      end
      S_PICK: begin
        v_nxt = '0;
        ctl.rd_addr = {best_r, node_t'(0)};
        if (!found_r || best_r == b_r) state_nxt = S_OUT;
        else state_nxt = S_RELAX;
      end
      S_RELAX: begin
        ctl.rd_addr = {u_r, v_r + 1'b1};
        v_nxt = v_r + 1'b1;
        if (last_v) state_nxt = S_RELAX_LAST;
      end
      S_RELAX_LAST: begin
        v_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    unique case (state_r)
      S_IDLE: begin
        op_r <= op_t'(in_tdata[1:0]); a_r <= in_tdata[6:2]; b_r <= in_tdata[11:7];
        w_r <= in_tdata[21:12]; tm_r <= in_tdata[22];
        status_r <= ST_DONE; res_cost_r <= '0;
        reached_r <= MaxNodes'(1) << in_tdata[6:2];
        settled_r <= '0;
        cost_r[in_tdata[6:2]] <= '0;
      end
      S_EDGE_WR: begin
        if (op_r == OP_ADD && rd_valid) status_r <= ST_PRESENT;
        if (op_r == OP_REMOVE && !rd_valid) status_r <= ST_ABSENT;
      end
      S_CLEAR, S_RELAX_LAST: begin
        found_r <= 1'b0; best_r <= '0; best_cost_r <= '0;
      end
      S_SCAN: begin
        if (reached_r[v_r] && !settled_r[v_r] &&
            (!found_r || cost_r[v_r] < best_cost_r)) begin
          found_r <= 1'b1; best_r <= v_r; best_cost_r <= cost_r[v_r];
        end
      end
      S_PICK: begin
        u_r <= best_r; cu_r <= best_cost_r;
        settled_r[best_r] <= 1'b1;
        if (!found_r) status_r <= ST_UNREACH;
        else if (best_r == b_r) res_cost_r <= best_cost_r;
      end
      S_RELAX: begin
        if (rd_valid && !settled_r[v_r] && (!reached_r[v_r] || nc < cost_r[v_r])) begin
          cost_r[v_r] <= nc; reached_r[v_r] <= 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for shortest_path_cost_engine: drives edge, query and no-op beats over the
// input stream and checks every result against its own path cost predictor.
// Depends on spce_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import spce_pkg::*;

  class route_scoreboard;
    localparam int QDepth = 1024;
    bit        link_on [MaxNodes][MaxNodes];
    bit [9:0]  link_w  [MaxNodes][MaxNodes];
    status_t   want_status[QDepth];
    bit [31:0] want_cost[QDepth];
    int        n_noted = 0;
    int        n_checked = 0;
    int        errors;

    function int pending();
      return n_noted - n_checked;
    endfunction

    function bit [31:0] hop(bit [9:0] w, bit tm);
      return tm ? 32'd120 + 32'd40 * w : {22'd0, w};
    endfunction

    function bit [31:0] sadd(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit cheapest(int src, int dst, bit tm, output bit [31:0] c);
      bit [31:0] best[MaxNodes];
      bit        seen[MaxNodes];
      bit        done[MaxNodes];
      int        u;
      bit        found;
      bit [31:0] nc;
      for (int i = 0; i < MaxNodes; i++) begin
        best[i] = 0; seen[i] = 0; done[i] = 0;
      end
      seen[src] = 1;
      for (int i = 0; i < MaxNodes; i++) begin
        found = 0; u = 0;
        for (int v = 0; v < MaxNodes; v++)
          if (seen[v] && !done[v] && (!found || best[v] < best[u])) begin
            u = v; found = 1;
          end
        if (!found) return 0;
        if (u == dst) begin
          c = best[u];
          return 1;
        end
        done[u] = 1;
        for (int v = 0; v < MaxNodes; v++)
          if (link_on[u][v] && !done[v]) begin
            nc = sadd(best[u], hop(link_w[u][v], tm));
            if (!seen[v] || nc < best[v]) begin
              best[v] = nc; seen[v] = 1;
            end
          end
      end
      return 0;
    endfunction

    function void note_item(bit [23:0] d);
      op_t       op;
      int        a, b;
      bit [9:0]  w;
      status_t   st;
      bit [31:0] c, q;
      op = op_t'(d[1:0]); a = int'(d[6:2]); b = int'(d[11:7]); w = d[21:12];
      st = ST_DONE; c = 0;
      case (op)
        OP_ADD: begin
          if (link_on[a][b]) st = ST_PRESENT;
          else begin
            link_on[a][b] = 1; link_on[b][a] = 1;
            link_w[a][b] = w; link_w[b][a] = w;
          end
        end
        OP_REMOVE: begin
          if (!link_on[a][b]) st = ST_ABSENT;
          else begin
            link_on[a][b] = 0; link_on[b][a] = 0;
          end
        end
        OP_QUERY: begin
          if (cheapest(a, b, d[22], q)) c = q;
          else st = ST_UNREACH;
        end
        default: ;
      endcase
      want_status[n_noted % QDepth] = st;
      want_cost[n_noted % QDepth] = c;
      n_noted++;
    endfunction

    function void check_result(bit [39:0] d);
      status_t   es;
      bit [31:0] ec;
      if (pending() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      es = want_status[n_checked % QDepth];
      ec = want_cost[n_checked % QDepth];
      n_checked++;
      if (d[1:0] != es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, d[1:0]);
        errors++;
      end
      if (d[33:2] != ec) begin
        $display("%0t: path_cost expected %0d actual %0d", $time, ec, d[33:2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;   // op, node_a, node_b, weight, time_mode
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;      // status, path_cost

  int send_idle = 0;
  int recv_stall = 0;
  route_scoreboard sb = new();

  shortest_path_cost_engine i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_beat(bit [1:0] op, bit [4:0] a, bit [4:0] b, bit [9:0] w, bit tm);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tdata  <= {1'b0, tm, w, b, a, op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_item({1'b0, tm, w, b, a, op});
    @(negedge clk);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_beat(OP_ADD, 5'($urandom_range(7)), 5'($urandom_range(7)), 10'($urandom),
                1'($urandom));
    else if (r < 60)
      send_beat(OP_REMOVE, 5'($urandom_range(7)), 5'($urandom_range(7)), 10'($urandom),
                1'($urandom));
    else if (r < 95)
      send_beat(OP_QUERY, 5'($urandom_range(7)), 5'($urandom_range(7)), 10'($urandom),
                1'($urandom));
    else
      send_beat(2'($urandom), 5'($urandom), 5'($urandom), 10'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_beat(OP_QUERY, 0, 31, 0, 0);
    send_beat(OP_QUERY, 5, 5, 0, 1);
    send_beat(OP_ADD, 0, 31, 10'h3FF, 0);
    send_beat(OP_ADD, 31, 0, 5, 0);
    send_beat(OP_QUERY, 0, 31, 0, 0);
    send_beat(OP_QUERY, 31, 0, 0, 1);
    send_beat(OP_ADD, 3, 3, 7, 0);
    send_beat(OP_ADD, 0, 1, 0, 0);
    send_beat(OP_ADD, 1, 31, 0, 0);
    send_beat(OP_QUERY, 0, 31, 0, 0);
    send_beat(OP_QUERY, 0, 31, 0, 1);
    send_beat(OP_QUERY, 3, 0, 0, 0);
    send_beat(OP_REMOVE, 0, 31, 0, 0);
    send_beat(OP_REMOVE, 0, 31, 0, 0);
    send_beat(OP_REMOVE, 2, 9, 0, 0);
    send_beat(OP_NONE, 31, 31, 10'h3FF, 1);
    send_beat(OP_QUERY, 31, 0, 0, 1);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: send_idle = 87;
        2: recv_stall = 87;
        3: begin send_idle = 27; recv_stall = 27; end
        4: begin send_idle = 0; recv_stall = 0; end
        default: ;
      endcase
      for (int k = 0; k < 116; k++) send_random();
    end
    in_tvalid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
